[src/fcdt_pkg.sv]
// fcdt_pkg: shared constants and word types for the frame crc dedup table
// used by the top level, the table ram instance and the port checker
package fcdt_pkg;

  // table geometry and length counter width
  localparam int MAX_FRAMES  = 1024;
  localparam int LENGTH_BITS = 24;
  localparam int IDX_W       = $clog2(MAX_FRAMES);
  localparam int CNT_W       = $clog2(MAX_FRAMES + 1);
  localparam int CRC_W       = 32;
  localparam int ENTRY_W     = CRC_W + LENGTH_BITS;

  // crc-32, msb first, no reflection
  localparam logic [CRC_W-1:0] CRC_POLY = 32'h04c1_1db7;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hffff_ffff;

  // saturation value of the length counter
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [CRC_W-1:0]       frame_crc;
    logic [LENGTH_BITS-1:0] frame_length;
    logic                   match_found;
    logic [IDX_W-1:0]       match_index;
    logic [IDX_W-1:0]       frame_number;
    logic                   table_full;
    logic                   length_overflow;
  } result_t;

endpackage

[src/frame_crc_dedup_table.sv]
// frame_crc_dedup_table: per-frame crc-32 and length with duplicate lookup
// depends on fcdt_pkg and fcdt_ram (frame table)
// a byte that is not last keeps busy high while the bit-serial crc shifter runs,
// so a new word is not taken until all bits of the last byte are shifted in
// a last byte adds a table scan, one entry per cycle through the ram read port:
// done strobes once the scan and then the finish step that stores the frame are through
// synchronous reset clears crc, count, flags and the stored frame count;
// the table itself is not cleared, only slots already written are scanned
module frame_crc_dedup_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  fcdt_pkg::in_word_t frame_in,
  output logic              busy,
  output logic              done,
  output fcdt_pkg::result_t result
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CRC    = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]                       state;
  logic [fcdt_pkg::CRC_W-1:0]       crc;
  logic [fcdt_pkg::LENGTH_BITS-1:0] byte_count;
  logic                             overflow_seen;
  logic [fcdt_pkg::CNT_W-1:0]       stored_frames;
  logic [2:0]                       bit_cnt;
  logic                             is_last;
  logic [fcdt_pkg::CNT_W-1:0]       scan;
  logic                             pend;
  logic [fcdt_pkg::IDX_W-1:0]       cmp_idx;
  logic                             found;
  logic [fcdt_pkg::IDX_W-1:0]       match_idx;

  logic                             ram_we;
  logic [fcdt_pkg::IDX_W-1:0]       ram_addr;
  logic [fcdt_pkg::ENTRY_W-1:0]     ram_wdata;
  logic [fcdt_pkg::ENTRY_W-1:0]     ram_rdata;

  logic [fcdt_pkg::CRC_W-1:0]       key_crc;
  logic                             full;
  logic                             scan_more;
  logic                             entry_hit;

  assign busy      = (state != ST_IDLE);
  assign key_crc   = ~crc;
  assign full      = (stored_frames == fcdt_pkg::CNT_W'(fcdt_pkg::MAX_FRAMES));
  assign scan_more = (scan < stored_frames);
  assign entry_hit = (ram_rdata[fcdt_pkg::ENTRY_W-1 -: fcdt_pkg::CRC_W] == key_crc) &&
                     (ram_rdata[fcdt_pkg::LENGTH_BITS-1:0] == byte_count);

  // table port: scan reads, one write when the frame is stored
  assign ram_we    = (state == ST_FINISH) && !full;
  assign ram_addr  = (state == ST_FINISH) ? stored_frames[fcdt_pkg::IDX_W-1:0]
                                          : scan[fcdt_pkg::IDX_W-1:0];
  assign ram_wdata = {key_crc, byte_count};

  fcdt_ram #(
    .WIDTH (fcdt_pkg::ENTRY_W),
    .DEPTH (fcdt_pkg::MAX_FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // sequencer, crc shifter, scan compare and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      crc           <= fcdt_pkg::CRC_INIT;
      byte_count    <= '0;
      overflow_seen <= 1'b0;
      stored_frames <= '0;
      done          <= 1'b0;
      pend          <= 1'b0;
    end else begin
      // strobe for one cycle as the finish step completes
      done <= (state == ST_FINISH);
      case (state)
        ST_IDLE: begin
          if (start) begin
            // fold the byte into the top of the crc, then shift it out
            crc     <= crc ^ {frame_in.data_byte, {(fcdt_pkg::CRC_W - 8){1'b0}}};
            is_last <= frame_in.last_byte;
            bit_cnt <= '0;
            if (byte_count != fcdt_pkg::LEN_MAX) begin
              byte_count <= byte_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
            state <= ST_CRC;
          end
        end
        ST_CRC: begin
          // one polynomial step per cycle
          if (crc[fcdt_pkg::CRC_W-1]) begin
            crc <= {crc[fcdt_pkg::CRC_W-2:0], 1'b0} ^ fcdt_pkg::CRC_POLY;
          end else begin
            crc <= {crc[fcdt_pkg::CRC_W-2:0], 1'b0};
          end
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == 3'd7) begin
            if (is_last) begin
              scan      <= '0;
              pend      <= 1'b0;
              found     <= 1'b0;
              match_idx <= '0;
              state     <= ST_SEARCH;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_SEARCH: begin
          // issue one read per cycle, compare the entry read last cycle
          pend    <= scan_more;
          cmp_idx <= scan[fcdt_pkg::IDX_W-1:0];
          if (scan_more) begin
            scan <= scan + 1'b1;
          end
          if (pend && entry_hit) begin
            found     <= 1'b1;
            match_idx <= cmp_idx;
          end
          if (!scan_more && !pend) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // store the frame if there is room and present the result word
          result.frame_crc       <= key_crc;
          result.frame_length    <= byte_count;
          result.match_found     <= found;
          result.match_index     <= match_idx;
          result.frame_number    <= full ? '0 : stored_frames[fcdt_pkg::IDX_W-1:0];
          result.table_full      <= full;
          result.length_overflow <= overflow_seen;
          if (!full) begin
            stored_frames <= stored_frames + 1'b1;
          end
          crc           <= fcdt_pkg::CRC_INIT;
          byte_count    <= '0;
          overflow_seen <= 1'b0;
          state         <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/fcdt_ram.sv]
// fcdt_ram: generic single port ram with registered read data
// no dependencies
module fcdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/fcdt_checker.sv]
// fcdt_checker: port-level checks for frame_crc_dedup_table, bound to the top level
// depends on fcdt_pkg for the result word type
module fcdt_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input fcdt_pkg::result_t result
);

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("block not idle after reset");

  // an accepted word raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted word");

  // a result only appears once the block is ready again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // a full table gives slot zero
  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    (done && result.table_full) |-> (result.frame_number == '0))
    else $error("frame number not zero on full table");

  // no match gives index zero
  a_nomatch_idx: assert property (@(posedge clk) disable iff (rst)
    (done && !result.match_found) |-> (result.match_index == '0))
    else $error("match index not zero without match");

endmodule

bind frame_crc_dedup_table fcdt_checker u_fcdt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
